FILE: rtl/htbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types and constants for the huffman tree bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

  localparam int NODES   = 512;
  localparam int NODE_AW = $clog2(NODES);
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 4;

  typedef enum logic [1:0] {
    CMD_NODE  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] symbol;
  } node_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_t              wdata;
    logic               re;
    logic [NODE_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return 32'(idx) < NODES;
  endfunction

endpackage

FILE: rtl/huffman_tree_bit_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_top
// Walks a code tree held in a node table, one code bit per table read.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | cmd, node_index, node_leaf, node_left,
//           |                      | node_right, node_symbol, data_byte,
//           |                      | pad_bits
//   out     | out_valid / out_stall| symbol, last
//
// a node write is taken in ST_IDLE; a data byte is walked one code bit per
// tree step, each step passing ST_STEP and ST_CHECK around the registered read.
// a step to an out-of-range child skips ST_CHECK and the table read.
// in_stall is high while a byte is being walked; the input is taken again
// as soon as the last symbol reaches the output register.
// a stalled output holds the walk only when a further symbol must leave.
// synchronous reset returns the walk to the root; the table is not cleared.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [htbd_pkg::IDX_W-1:0] node_index,
  input  logic                       node_leaf,
  input  logic [htbd_pkg::IDX_W-1:0] node_left,
  input  logic [htbd_pkg::IDX_W-1:0] node_right,
  input  logic [htbd_pkg::SYM_W-1:0] node_symbol,
  input  logic [7:0]                 data_byte,
  input  logic [2:0]                 pad_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [htbd_pkg::SYM_W-1:0] symbol,
  output logic                       last
);

  htbd_pkg::state_t state, state_next;

  htbd_pkg::ram_req_t req;
  htbd_pkg::node_t    rd_q;
  htbd_pkg::node_t    root_entry;
  htbd_pkg::node_t    cur_entry;

  logic [7:0]                 byte_sr;
  logic [htbd_pkg::CNT_W-1:0] bits_left;
  logic                       fin;
  logic                       at_root;
  logic [htbd_pkg::IDX_W-1:0] cur_idx;
  logic                       pend_valid;
  logic [htbd_pkg::SYM_W-1:0] pend_sym;

  logic                       is_data;
  logic                       accept;
  logic [htbd_pkg::IDX_W-1:0] child;
  logic                       child_ok;
  logic                       bits_done;
  logic                       check_blocked;
  logic                       flush_blocked;

  logic                       push;
  logic [htbd_pkg::SYM_W-1:0] push_symbol;
  logic                       push_last;
  logic                       can_push;

  assign is_data   = (cmd == htbd_pkg::CMD_DATA) || (cmd == htbd_pkg::CMD_FINAL);
  assign in_stall  = (state != htbd_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cur_entry = at_root ? root_entry : rd_q;
  assign child     = byte_sr[7] ? cur_entry.right : cur_entry.left;
  assign child_ok  = htbd_pkg::idx_ok(child);
  assign bits_done = (bits_left == '0);

  // a new leaf can only be parked once the previous one has gone out
  assign check_blocked = rd_q.leaf && pend_valid && !can_push;
  assign flush_blocked = pend_valid && !can_push;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      htbd_pkg::ST_IDLE: begin
        if (accept && is_data) begin
          state_next = htbd_pkg::ST_STEP;
        end
      end
      htbd_pkg::ST_STEP: begin
        if (bits_done) begin
          state_next = htbd_pkg::ST_FLUSH;
        end else if (child_ok) begin
          state_next = htbd_pkg::ST_CHECK;
        end
      end
      htbd_pkg::ST_CHECK: begin
        if (!check_blocked) begin
          state_next = htbd_pkg::ST_STEP;
        end
      end
      htbd_pkg::ST_FLUSH: begin
        if (!flush_blocked) begin
          state_next = htbd_pkg::ST_IDLE;
        end
      end
      default: state_next = htbd_pkg::ST_IDLE;
    endcase
  end

  // table port and output pushes
  always_comb begin
    req         = '0;
    push        = 1'b0;
    push_symbol = pend_sym;
    push_last   = 1'b0;
    case (state)
      htbd_pkg::ST_IDLE: begin
        req.we    = accept && (cmd == htbd_pkg::CMD_NODE) && htbd_pkg::idx_ok(node_index);
        req.waddr = htbd_pkg::NODE_AW'(node_index);
        req.wdata = '{leaf: node_leaf, left: node_left, right: node_right,
                      symbol: node_symbol};
        // refetch the current node in case the table changed since the last byte
        req.re    = accept && is_data;
        req.raddr = htbd_pkg::NODE_AW'(cur_idx);
      end
      htbd_pkg::ST_STEP: begin
        req.re    = !bits_done && child_ok;
        req.raddr = htbd_pkg::NODE_AW'(child);
      end
      htbd_pkg::ST_CHECK: begin
        push = rd_q.leaf && pend_valid && can_push;
      end
      htbd_pkg::ST_FLUSH: begin
        push      = pend_valid && can_push;
        push_last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htbd_pkg::ST_IDLE;
      at_root    <= 1'b1;
      pend_valid <= 1'b0;
      bits_left  <= '0;
      fin        <= 1'b0;
      cur_idx    <= '0;
    end else begin
      state <= state_next;
      case (state)
        htbd_pkg::ST_IDLE: begin
          if (accept && is_data) begin
            fin <= (cmd == htbd_pkg::CMD_FINAL);
            if (cmd == htbd_pkg::CMD_FINAL) begin
              bits_left <= htbd_pkg::CNT_W'(8) - htbd_pkg::CNT_W'(pad_bits);
            end else begin
              bits_left <= htbd_pkg::CNT_W'(8);
            end
          end
        end
        htbd_pkg::ST_STEP: begin
          if (!bits_done) begin
            bits_left <= bits_left - 1'b1;
            if (child_ok) begin
              cur_idx <= child;
            end else begin
              at_root <= 1'b1;
            end
          end
        end
        htbd_pkg::ST_CHECK: begin
          if (!check_blocked) begin
            if (rd_q.leaf) begin
              pend_valid <= 1'b1;
              at_root    <= 1'b1;
            end else begin
              at_root <= 1'b0;
            end
          end
        end
        htbd_pkg::ST_FLUSH: begin
          if (!flush_blocked) begin
            pend_valid <= 1'b0;
            if (fin) begin
              at_root <= 1'b1;
            end
          end
        end
        default: begin
          at_root <= 1'b1;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && is_data) begin
      byte_sr <= data_byte;
    end else if (state == htbd_pkg::ST_STEP && !bits_done) begin
      byte_sr <= {byte_sr[6:0], 1'b0};
    end
    if (state == htbd_pkg::ST_CHECK && !check_blocked && rd_q.leaf) begin
      pend_sym <= rd_q.symbol;
    end
    if (req.we && (node_index == '0)) begin
      root_entry <= req.wdata;
    end
  end

  htbd_node_ram u_node_ram (
    .clk  (clk),
    .req  (req),
    .rd_q (rd_q)
  );

  htbd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_symbol (push_symbol),
    .push_last   (push_last),
    .can_push    (can_push),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last)
  );

endmodule

FILE: rtl/htbd_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_node_ram
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module htbd_node_ram (
  input  logic              clk,
  input  htbd_pkg::ram_req_t req,
  output htbd_pkg::node_t   rd_q
);

  htbd_pkg::node_t mem [htbd_pkg::NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/htbd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_out_reg
// Output register for decoded symbols, decouples the walk from the sink.
// ----------------------------------------------------------------------------
module htbd_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [htbd_pkg::SYM_W-1:0] push_symbol,
  input  logic                       push_last,
  output logic                       can_push,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [htbd_pkg::SYM_W-1:0] symbol,
  output logic                       last
);

  assign can_push = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_push) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      symbol <= push_symbol;
      last   <= push_last;
    end
  end

endmodule
